// File: rtl/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// Shared types and constants for the tree-table huffman decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

    localparam int TREE_BYTES = 512;
    localparam int TREE_AW    = $clog2(TREE_BYTES);
    localparam int REACH_D    = TREE_BYTES + 1;
    localparam int REACH_AW   = $clog2(REACH_D);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT_HDR = 3'd1,
        ST_SHORT_TREE= 3'd2,
        ST_BAD_CHILD = 3'd3,
        ST_NO_STREAM = 3'd4,
        ST_TRUNC     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_HDR,
        S_TCNT,
        S_TBODY,
        S_CFETCH,
        S_CEVAL,
        S_CWR0,
        S_CWR1,
        S_STREAM,
        S_DFETCH,
        S_DEVAL,
        S_SFETCH,
        S_SYM,
        S_FLUSH,
        S_FIN,
        S_DONE
    } t_state;

endpackage

// File: rtl/huffman_tree_table_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_tree_table_decoder_top
// Header and tree bytes: stored on accept. Tree check: fetch, evaluate and,
// for a reachable node, two child marks. Bitstream word: fetch and evaluate
// per bit, fetch and emit per leaf, then close; input stalls while busy.
// Synchronous active-low reset clears control state; no memory clear pass.
// ----------------------------------------------------------------------------
module huffman_tree_table_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_done_res,
    output htd_pkg::t_status o_status
);
    import htd_pkg::*;

    t_state      r_state, n_state;
    logic        r_mode_cfg, r_mode, n_mode;
    logic [7:0]  r_hdr [8];
    logic [9:0]  r_bc, n_bc;
    logic [9:0]  r_tlen, n_tlen;
    logic        r_tlast, n_tlast;
    logic [9:0]  r_off, n_off;
    logic [9:0]  r_base, n_base;
    logic [1:0]  r_wrk, n_wrk;
    logic [31:0] r_word, n_word;
    logic [5:0]  r_bits, n_bits;
    logic [9:0]  r_node, n_node;
    logic [9:0]  r_child, n_child;
    logic [32:0] r_syms, n_syms;
    logic [3:0]  r_nib, n_nib;
    logic        r_nheld, n_nheld;
    logic        r_last, n_last;
    t_status     r_st, n_st;
    logic        r_pv, n_pv;
    logic [7:0]  r_pbyte, n_pbyte;
    logic        r_ov, n_ov;
    logic [7:0]  r_obyte, n_obyte;
    logic        r_obv, n_obv;
    logic        r_odone, n_odone;
    t_status     r_ost, n_ost;

    logic                t_we;
    logic [TREE_AW-1:0]  t_addr;
    logic [7:0]          t_rdata;
    logic                c_we;
    logic [REACH_AW-1:0] c_addr;
    logic                c_wdata;
    logic                c_rdata;

    logic        w_acc, w_ofree, w_hwe;
    logic [9:0]  w_step, w_base, w_child, w_nbc;
    logic [31:0] w_s;
    logic        w_bit, w_leaf, w_new;
    logic [7:0]  w_newbyte;

    htd_ram #(.WIDTH(8), .DEPTH(TREE_BYTES)) u_tree (
        .i_clk(i_clk), .i_we(t_we), .i_addr(t_addr), .i_wdata(i_data_byte),
        .o_rdata(t_rdata)
    );

    htd_ram #(.WIDTH(1), .DEPTH(REACH_D)) u_reach (
        .i_clk(i_clk), .i_we(c_we), .i_addr(c_addr), .i_wdata(c_wdata),
        .o_rdata(c_rdata)
    );

    assign o_stall = !(r_state == S_HDR || r_state == S_TCNT || r_state == S_TBODY ||
                       r_state == S_STREAM || r_state == S_DONE);
    assign w_acc   = i_valid && !o_stall;
    assign w_ofree = !r_ov || !i_stall;
    assign w_step  = {2'b00, {1'b0, t_rdata[5:0]} + 7'd1, 1'b0};
    assign w_base  = {r_off[9:1], 1'b0} + w_step;
    assign w_bit   = r_word[31];
    assign w_child = {r_node[9:1], 1'b0} + w_step + {9'd0, w_bit};
    assign w_leaf  = w_bit ? t_rdata[6] : t_rdata[7];
    assign w_nbc   = r_bc + 10'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_cfg <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            r_hdr[r_bc[2:0]] <= i_data_byte;
        end
    end

    always_comb begin
        n_state = r_state;  n_mode = r_mode;    n_bc = r_bc;       n_tlen = r_tlen;
        n_tlast = r_tlast;  n_off = r_off;      n_base = r_base;   n_wrk = r_wrk;
        n_word = r_word;    n_bits = r_bits;    n_node = r_node;   n_child = r_child;
        n_syms = r_syms;    n_nib = r_nib;      n_nheld = r_nheld; n_last = r_last;
        n_st = r_st;        n_pv = r_pv;        n_pbyte = r_pbyte;
        n_ov = r_ov && i_stall;
        n_obyte = r_obyte;  n_obv = r_obv;      n_odone = r_odone; n_ost = r_ost;
        w_hwe = 1'b0;
        t_we = 1'b0;  t_addr = r_node[TREE_AW-1:0] - 1'b1;
        c_we = 1'b0;  c_addr = r_off[REACH_AW-1:0]; c_wdata = 1'b0;
        w_s = 32'd0;
        w_new = 1'b0;
        w_newbyte = t_rdata;

        case (r_state)
            S_HDR: begin
                if (w_acc) begin
                    w_hwe = 1'b1;
                    n_bc = w_nbc;
                    if (r_bc == 10'd3 || r_bc == 10'd7) begin
                        if (r_bc == 10'd3) begin
                            w_s = {8'd0, i_data_byte, r_hdr[2], r_hdr[1]};
                        end else begin
                            w_s = {i_data_byte, r_hdr[6], r_hdr[5], r_hdr[4]};
                        end
                        if (w_s != 32'd0) begin
                            n_mode = r_mode_cfg;
                            n_syms = r_mode_cfg ? {w_s, 1'b0} : {1'b0, w_s};
                            n_bc = 10'd0;
                            if (i_last_byte) begin
                                n_st = ST_SHORT_TREE;
                                n_state = S_FIN;
                            end else begin
                                n_state = S_TCNT;
                            end
                        end else if (r_bc == 10'd7) begin
                            n_st = ST_OK;
                            n_state = S_FIN;
                        end else if (i_last_byte) begin
                            n_st = ST_SHORT_HDR;
                            n_state = S_FIN;
                        end
                    end else if (i_last_byte) begin
                        n_st = ST_SHORT_HDR;
                        n_state = S_FIN;
                    end
                end
            end
            S_TCNT: begin
                if (w_acc) begin
                    if ((({2'b00, i_data_byte} + 10'd1) << 1) > 10'(TREE_BYTES) ||
                        i_last_byte) begin
                        n_st = ST_SHORT_TREE;
                        n_state = S_FIN;
                    end else begin
                        n_tlen = (({2'b00, i_data_byte} + 10'd1) << 1) + 10'd1;
                        n_bc = 10'd0;
                        n_state = S_TBODY;
                    end
                end
            end
            S_TBODY: begin
                t_addr = r_bc[TREE_AW-1:0];
                c_addr = w_nbc[REACH_AW-1:0];
                if (w_acc) begin
                    t_we = 1'b1;
                    c_we = 1'b1;
                    n_bc = w_nbc;
                    if (w_nbc + 10'd1 >= r_tlen) begin
                        n_tlast = i_last_byte;
                        n_off = 10'd1;
                        n_state = S_CFETCH;
                    end else if (i_last_byte) begin
                        n_st = ST_SHORT_TREE;
                        n_state = S_FIN;
                    end
                end
            end
            S_CFETCH: begin
                t_addr = r_off[TREE_AW-1:0] - 1'b1;
                n_state = S_CEVAL;
            end
            S_CEVAL: begin
                if (c_rdata || r_off == 10'd1) begin
                    if (w_base + 10'd1 >= r_tlen) begin
                        n_st = ST_BAD_CHILD;
                        n_state = S_FIN;
                    end else begin
                        n_base = w_base;
                        n_wrk = t_rdata[7:6];
                        n_state = S_CWR0;
                    end
                end else begin
                    n_off = r_off + 10'd1;
                    n_state = S_CFETCH;
                    if (r_off + 10'd1 >= r_tlen) begin
                        n_state = r_tlast ? S_FIN : S_STREAM;
                        n_st = ST_NO_STREAM;
                        n_bc = 10'd0; n_word = 32'd0; n_node = 10'd1;
                    end
                end
            end
            S_CWR0: begin
                c_addr = r_base[REACH_AW-1:0];
                c_wdata = 1'b1;
                c_we = !r_wrk[1];
                n_state = S_CWR1;
            end
            S_CWR1: begin
                c_addr = r_base[REACH_AW-1:0] + 1'b1;
                c_wdata = 1'b1;
                c_we = !r_wrk[0];
                n_off = r_off + 10'd1;
                n_state = S_CFETCH;
                if (r_off + 10'd1 >= r_tlen) begin
                    n_state = r_tlast ? S_FIN : S_STREAM;
                    n_st = ST_NO_STREAM;
                    n_bc = 10'd0; n_word = 32'd0; n_node = 10'd1;
                end
            end
            S_STREAM: begin
                if (w_acc) begin
                    case (r_bc[1:0])
                        2'd0:    n_word = r_word | {24'd0, i_data_byte};
                        2'd1:    n_word = r_word | {16'd0, i_data_byte, 8'd0};
                        2'd2:    n_word = r_word | {8'd0, i_data_byte, 16'd0};
                        default: n_word = r_word | {i_data_byte, 24'd0};
                    endcase
                    n_bc = {8'd0, r_bc[1:0] + 2'd1};
                    if (r_bc[1:0] == 2'd3 || i_last_byte) begin
                        n_bits = {1'b0, r_bc[1:0] + 3'd1, 2'd0} << 1;
                        n_last = i_last_byte;
                        n_state = S_DFETCH;
                    end
                end
            end
            S_DFETCH: begin
                n_state = S_DEVAL;
            end
            S_DEVAL: begin
                n_word = r_word << 1;
                n_bits = r_bits - 6'd1;
                if (w_leaf) begin
                    n_child = w_child;
                    n_state = S_SFETCH;
                end else begin
                    n_node = w_child;
                    n_state = (r_bits == 6'd1) ? (r_last ? S_FIN : S_FLUSH) : S_DFETCH;
                    n_st = ST_TRUNC;
                end
            end
            S_SFETCH: begin
                t_addr = r_child[TREE_AW-1:0] - 1'b1;
                n_state = S_SYM;
            end
            S_SYM: begin
                t_addr = r_child[TREE_AW-1:0] - 1'b1;
                if (r_mode) begin
                    w_new = r_nheld;
                    w_newbyte = {t_rdata[3:0], r_nib};
                end else begin
                    w_new = 1'b1;
                end
                if (!(w_new && r_pv && !w_ofree)) begin
                    n_syms = r_syms - 33'd1;
                    n_node = 10'd1;
                    if (r_mode) begin
                        n_nheld = !r_nheld;
                        n_nib = t_rdata[3:0];
                    end
                    if (w_new) begin
                        if (r_pv) begin
                            n_ov = 1'b1; n_obyte = r_pbyte; n_obv = 1'b1;
                            n_odone = 1'b0; n_ost = ST_OK;
                        end
                        n_pv = 1'b1;
                        n_pbyte = w_newbyte;
                    end
                    if (r_syms == 33'd1) begin
                        n_st = ST_OK;
                        n_state = S_FIN;
                    end else if (r_bits == 6'd0) begin
                        n_st = ST_TRUNC;
                        n_state = r_last ? S_FIN : S_FLUSH;
                    end else begin
                        n_state = S_DFETCH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pv) begin
                    n_bc = 10'd0; n_word = 32'd0;
                    n_state = S_STREAM;
                end else if (w_ofree) begin
                    n_ov = 1'b1; n_obyte = r_pbyte; n_obv = 1'b1;
                    n_odone = 1'b0; n_ost = ST_OK;
                    n_pv = 1'b0;
                end
            end
            S_FIN: begin
                if (w_ofree) begin
                    n_ov = 1'b1;
                    n_obyte = r_pv ? r_pbyte : 8'd0;
                    n_obv = r_pv;
                    n_odone = 1'b1;
                    n_ost = r_st;
                    n_pv = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
            end
            default: begin
                n_state = S_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HDR;  r_mode <= 1'b0;   r_bc <= '0;      r_tlen <= '0;
            r_tlast <= 1'b0;   r_off <= 10'd1;   r_base <= '0;    r_wrk <= '0;
            r_word <= '0;      r_bits <= '0;     r_node <= 10'd1; r_child <= 10'd1;
            r_syms <= '0;      r_nib <= '0;      r_nheld <= 1'b0; r_last <= 1'b0;
            r_st <= ST_OK;     r_pv <= 1'b0;     r_pbyte <= '0;   r_ov <= 1'b0;
            r_obyte <= '0;     r_obv <= 1'b0;    r_odone <= 1'b0; r_ost <= ST_OK;
        end else begin
            r_state <= n_state; r_mode <= n_mode;   r_bc <= n_bc;       r_tlen <= n_tlen;
            r_tlast <= n_tlast; r_off <= n_off;     r_base <= n_base;   r_wrk <= n_wrk;
            r_word <= n_word;   r_bits <= n_bits;   r_node <= n_node;   r_child <= n_child;
            r_syms <= n_syms;   r_nib <= n_nib;     r_nheld <= n_nheld; r_last <= n_last;
            r_st <= n_st;       r_pv <= n_pv;       r_pbyte <= n_pbyte; r_ov <= n_ov;
            r_obyte <= n_obyte; r_obv <= n_obv;     r_odone <= n_odone; r_ost <= n_ost;
        end
    end

    assign o_valid      = r_ov;
    assign o_out_byte   = r_obyte;
    assign o_byte_valid = r_obv;
    assign o_done_res   = r_odone;
    assign o_status     = r_ost;

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_state == S_DONE)
        else $error("left done state");

    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> o_status == ST_OK)
        else $error("status on non-final transfer");

    a_empty_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_done_res)
        else $error("empty transfer not final");

    a_pend_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STREAM |-> !r_pv)
        else $error("held byte across words");

endmodule

// File: rtl/htd_ram.sv
// ----------------------------------------------------------------------------
// htd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
